// ----- rtl/rdss_pkg.sv -----
// ----------------------------------------------------------------------------
// rdss_pkg
// Shared types, constants and arithmetic helpers for the disk/slider step core.
// ----------------------------------------------------------------------------
package rdss_pkg;

  localparam int unsigned QW         = 32;   // Q16.16 word width
  localparam int unsigned DTW        = 24;   // Q0.24 time step width
  localparam int unsigned CFGW       = 26;   // widest configuration register
  localparam int unsigned CFG_IDXW   = 3;
  localparam int unsigned DIV_QW     = 48;   // quotient bits of numerator * 2^16
  localparam int unsigned DIV_CNTW   = 5;
  localparam logic [DIV_CNTW-1:0] DIV_STEPS = 5'd24;  // two quotient bits a cycle

  localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

  // reset values
  localparam logic signed [17:0] RST_DAMPING      = 18'sd6554;
  localparam logic [25:0]        RST_STIFFNESS    = 26'd6553600;
  localparam logic [16:0]        RST_REST_LENGTH  = 17'd32768;
  localparam logic [22:0]        RST_SLIDER_MASS  = 23'd65536;
  localparam logic [25:0]        RST_DISK_INERTIA = 26'd327680;
  localparam logic signed [QW-1:0] RST_SPIN_RATE  = 32'sd131072;

  // configuration register indexes
  localparam logic [CFG_IDXW-1:0] CFG_DAMPING      = 3'd0;
  localparam logic [CFG_IDXW-1:0] CFG_STIFFNESS    = 3'd1;
  localparam logic [CFG_IDXW-1:0] CFG_REST_LENGTH  = 3'd2;
  localparam logic [CFG_IDXW-1:0] CFG_SLIDER_MASS  = 3'd3;
  localparam logic [CFG_IDXW-1:0] CFG_DISK_INERTIA = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DB, ST_DBW, ST_DK, ST_DKW,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
    ST_M9, ST_M10, ST_M11, ST_M12, ST_M13, ST_M14, ST_M15, ST_M16,
    ST_NUM, ST_DN, ST_DNW,
    ST_W1, ST_W2, ST_W3, ST_W4
  } state_t;

  // saturated value and its clamp flag
  typedef struct packed {
    logic                   sat;
    logic signed [QW-1:0]   val;
  } sres_t;

  typedef struct packed {
    logic [QW-1:0]     rem;
    logic [DIV_QW-1:0] quo;
  } div_st_t;

  function automatic sres_t sat_clip(input logic signed [49:0] v);
    sres_t r;
    if (v > 50'sh0_0000_7FFF_FFFF) begin
      r.sat = 1'b1;
      r.val = Q_MAX;
    end else if (v < -50'sh0_0000_8000_0000) begin
      r.sat = 1'b1;
      r.val = Q_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = v[QW-1:0];
    end
    return r;
  endfunction

  // a + b, or a - b when sub is set, saturated
  function automatic sres_t sat_add(input logic signed [QW-1:0] a,
                                    input logic signed [QW-1:0] b,
                                    input logic sub);
    logic signed [33:0] s;
    if (sub) s = {{2{a[31]}}, a} - {{2{b[31]}}, b};
    else     s = {{2{a[31]}}, a} + {{2{b[31]}}, b};
    return sat_clip({{16{s[33]}}, s});
  endfunction

  // Q16.16 product: round half up, then saturate
  function automatic sres_t q_round(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd32768;
    return sat_clip({{2{s[63]}}, s[63:16]});
  endfunction

  // time step product: round half up, always in range
  function automatic logic signed [QW-1:0] t_round(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd8388608;
    return s[55:24];
  endfunction

  // one restoring division step
  function automatic div_st_t div_step(input div_st_t s, input logic [QW-1:0] d);
    logic [QW:0] t;
    logic        b;
    div_st_t     r;
    t = {s.rem, s.quo[DIV_QW-1]};
    b = (t >= {1'b0, d});
    if (b) t = t - {1'b0, d};
    r.rem = t[QW-1:0];
    r.quo = {s.quo[DIV_QW-2:0], b};
    return r;
  endfunction

  // signed, saturated quotient from magnitude and flags
  function automatic sres_t div_result(input logic [DIV_QW-1:0] quo, input logic neg,
                                       input logic zero, input logic nz);
    sres_t r;
    if (zero) begin
      r.sat = nz;
      r.val = nz ? (neg ? Q_MIN : Q_MAX) : '0;
    end else if (neg) begin
      r.sat = (quo > 48'h0000_8000_0000);
      r.val = r.sat ? Q_MIN : (~quo[QW-1:0] + 32'd1);
    end else begin
      r.sat = (quo > 48'h0000_7FFF_FFFF);
      r.val = r.sat ? Q_MAX : quo[QW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/rotating_disk_spring_slider_step_core.sv -----
// ----------------------------------------------------------------------------
// rotating_disk_spring_slider_step_core
// One semi-implicit Euler tick of a spring-damped slider on a spinning disk.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one word per simulation tick carrying
//   the applied z torque, the time step (unsigned Q0.24) and a freeze flag.
//   Output channel (out_valid / out_stall): one word per input word with the
//   slider position, the disk rotation over the tick, the new angular speed
//   and a flag that is set when any value clamped during the tick.
//   Configuration: cfg_we / cfg_index / cfg_data write damping, stiffness,
//   rest length, slider mass and disk inertia. Write only while idle.
//   The first tick after reset or after any register write divides b/m and
//   k/m afresh and caches them; a zero divisor cuts its division short.
//   in_stall is high while a tick works, so no new word is taken until the
//   tick ends.
//   The cost is set by one shared 32x32 multiplier, used at most once per
//   cycle, and a radix-4 restoring divider.
//   Reset: registers go to their reset values, the slider sits offset from
//   rest length by the reset rest length, radial rate is zero and the disk
//   spins at 2 rad/s.
//   Receiver stall: the result word is held in the output register; a new
//   input word is still taken, and its result waits at the end of its tick
//   until the output register frees.
// ----------------------------------------------------------------------------
module rotating_disk_spring_slider_step_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [25:0]                 cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          in_torque,
  input  logic [23:0]                 in_time_step,
  input  logic                        in_freeze,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_slider_position,
  output logic signed [31:0]          out_rotation_step,
  output logic signed [31:0]          out_angular_speed,
  output logic                        out_saturated
);

  // configuration registers
  logic signed [17:0] damping_r;
  logic [25:0]        stiffness_r;
  logic [16:0]        rest_length_r;
  logic [22:0]        slider_mass_r;
  logic [25:0]        disk_inertia_r;
  logic               dirty_r;       // cached ratios need recomputing

  // integrator state
  logic signed [31:0] x_r, xd_r, w_r;

  // per-tick working registers
  rdss_pkg::state_t   state_r, state_nxt;
  logic signed [31:0] tz_r;
  logic [23:0]        dt_r;
  logic               frz_r;
  logic               flag_r;
  logic signed [31:0] qb_r, qk_r;    // b/m and k/m, cached
  logic               sat_b_r, sat_k_r;
  logic signed [31:0] w2_r, t_r, kw_r, acc_r, r_r, p_r, den_r, num_r, q_r;

  // shared multiplier
  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] prod_r;
  rdss_pkg::sres_t    qm;
  logic signed [31:0] tm;

  // shared divider
  logic signed [31:0] div_n, div_d;
  logic [31:0]        div_nmag, div_dmag;
  logic [31:0]        div_dmag_r;
  logic [31:0]        div_rem_r;
  logic [47:0]        div_quo_r;
  logic [4:0]         div_cnt_r;
  logic               div_neg_r, div_zero_r, div_nz_r;
  logic               div_done;
  rdss_pkg::div_st_t  div_s0, div_s1, div_s2;
  rdss_pkg::sres_t    dres;

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_pos_r, out_rot_r, out_w_r;
  logic               out_sat_r;
  logic               out_free;

  // widened operands
  logic signed [31:0] dt_s, m_s, ln_s, izz_s, k_s, b_s;

  // saturating adders used by the sequencer
  rdss_pkg::sres_t    kw_c, acc_a_c, acc_b_c, xd_c, x_c, r_c, den_c, p2_c, num_c, w_c;

  assign dt_s  = $signed({8'd0, dt_r});
  assign m_s   = $signed({9'd0, slider_mass_r});
  assign ln_s  = $signed({15'd0, rest_length_r});
  assign izz_s = $signed({6'd0, disk_inertia_r});
  assign k_s   = $signed({6'd0, stiffness_r});
  assign b_s   = {{14{damping_r[17]}}, damping_r};

  assign in_stall = (state_r != rdss_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign mul_p = mul_a * mul_b;
  assign qm    = rdss_pkg::q_round(prod_r);
  assign tm    = rdss_pkg::t_round(prod_r);

  assign kw_c    = rdss_pkg::sat_add(qk_r, w2_r, 1'b1);
  assign acc_a_c = rdss_pkg::sat_add(qm.val, t_r, 1'b1);
  assign acc_b_c = rdss_pkg::sat_add(acc_r, qm.val, 1'b1);
  assign xd_c    = rdss_pkg::sat_add(xd_r, tm, 1'b0);
  assign x_c     = rdss_pkg::sat_add(x_r, tm, 1'b0);
  assign r_c     = rdss_pkg::sat_add(x_r, ln_s, 1'b0);
  assign den_c   = rdss_pkg::sat_add(izz_s, qm.val, 1'b0);
  assign p2_c    = rdss_pkg::sat_clip({{17{p_r[31]}}, p_r, 1'b0});
  assign num_c   = rdss_pkg::sat_add(tz_r, p2_c.val, 1'b1);
  assign w_c     = rdss_pkg::sat_add(w_r, tm, 1'b0);

  // divider: magnitudes on start, two restoring steps a cycle
  assign div_nmag = div_n[31] ? (~div_n + 32'sd1) : div_n;
  assign div_dmag = div_d[31] ? (~div_d + 32'sd1) : div_d;
  assign div_s0   = '{rem: div_rem_r, quo: div_quo_r};
  assign div_s1   = rdss_pkg::div_step(div_s0, div_dmag_r);
  assign div_s2   = rdss_pkg::div_step(div_s1, div_dmag_r);
  assign div_done = (div_cnt_r == rdss_pkg::DIV_STEPS);
  assign dres     = rdss_pkg::div_result(div_quo_r, div_neg_r, div_zero_r, div_nz_r);

  // sequencer: next state and unit operand selection
  always_comb begin
    state_nxt = state_r;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_n     = '0;
    div_d     = '0;
    case (state_r)
      rdss_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = dirty_r ? rdss_pkg::ST_DB : rdss_pkg::ST_M1;
      end
      rdss_pkg::ST_DB: begin
        div_n = b_s; div_d = m_s;
        state_nxt = rdss_pkg::ST_DBW;
      end
      rdss_pkg::ST_DBW: begin
        if (div_done) state_nxt = rdss_pkg::ST_DK;
      end
      rdss_pkg::ST_DK: begin
        div_n = k_s; div_d = m_s;
        state_nxt = rdss_pkg::ST_DKW;
      end
      rdss_pkg::ST_DKW: begin
        if (div_done) state_nxt = rdss_pkg::ST_M1;
      end
      rdss_pkg::ST_M1: begin
        mul_en = 1'b1; mul_a = w_r; mul_b = w_r;
        state_nxt = rdss_pkg::ST_M2;
      end
      rdss_pkg::ST_M2: begin
        mul_en = 1'b1; mul_a = qb_r; mul_b = xd_r;
        state_nxt = rdss_pkg::ST_M3;
      end
      rdss_pkg::ST_M3: begin
        mul_en = 1'b1; mul_a = w2_r; mul_b = ln_s;
        state_nxt = rdss_pkg::ST_M4;
      end
      rdss_pkg::ST_M4: begin
        mul_en = 1'b1; mul_a = kw_r; mul_b = x_r;
        state_nxt = rdss_pkg::ST_M5;
      end
      rdss_pkg::ST_M5: state_nxt = rdss_pkg::ST_M6;
      rdss_pkg::ST_M6: begin
        mul_en = 1'b1; mul_a = acc_r; mul_b = dt_s;
        state_nxt = rdss_pkg::ST_M7;
      end
      rdss_pkg::ST_M7: state_nxt = rdss_pkg::ST_M8;
      rdss_pkg::ST_M8: begin
        mul_en = 1'b1; mul_a = xd_r; mul_b = dt_s;
        state_nxt = rdss_pkg::ST_M9;
      end
      rdss_pkg::ST_M9:  state_nxt = rdss_pkg::ST_M10;
      rdss_pkg::ST_M10: state_nxt = rdss_pkg::ST_M11;
      rdss_pkg::ST_M11: begin
        mul_en = 1'b1; mul_a = m_s; mul_b = r_r;
        state_nxt = rdss_pkg::ST_M12;
      end
      rdss_pkg::ST_M12: begin
        mul_en = 1'b1; mul_a = r_r; mul_b = r_r;
        state_nxt = rdss_pkg::ST_M13;
      end
      rdss_pkg::ST_M13: begin
        mul_en = 1'b1; mul_a = p_r; mul_b = w_r;
        state_nxt = rdss_pkg::ST_M14;
      end
      rdss_pkg::ST_M14: begin
        mul_en = 1'b1; mul_a = m_s; mul_b = t_r;
        state_nxt = rdss_pkg::ST_M15;
      end
      rdss_pkg::ST_M15: begin
        mul_en = 1'b1; mul_a = p_r; mul_b = xd_r;
        state_nxt = rdss_pkg::ST_M16;
      end
      rdss_pkg::ST_M16: state_nxt = rdss_pkg::ST_NUM;
      rdss_pkg::ST_NUM: state_nxt = rdss_pkg::ST_DN;
      rdss_pkg::ST_DN: begin
        div_n = num_r; div_d = den_r;
        state_nxt = rdss_pkg::ST_DNW;
      end
      rdss_pkg::ST_DNW: begin
        if (div_done) state_nxt = rdss_pkg::ST_W1;
      end
      rdss_pkg::ST_W1: begin
        mul_en = 1'b1; mul_a = q_r; mul_b = dt_s;
        state_nxt = rdss_pkg::ST_W2;
      end
      rdss_pkg::ST_W2: state_nxt = rdss_pkg::ST_W3;
      rdss_pkg::ST_W3: begin
        mul_en = 1'b1; mul_a = w_r; mul_b = dt_s;
        state_nxt = rdss_pkg::ST_W4;
      end
      rdss_pkg::ST_W4: begin
        // hold until the output register can take the word
        if (out_free) state_nxt = rdss_pkg::ST_IDLE;
      end
      default: state_nxt = rdss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rdss_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration registers; any write marks the cached ratios stale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damping_r      <= rdss_pkg::RST_DAMPING;
      stiffness_r    <= rdss_pkg::RST_STIFFNESS;
      rest_length_r  <= rdss_pkg::RST_REST_LENGTH;
      slider_mass_r  <= rdss_pkg::RST_SLIDER_MASS;
      disk_inertia_r <= rdss_pkg::RST_DISK_INERTIA;
      dirty_r        <= 1'b1;
    end else if (cfg_we) begin
      dirty_r <= 1'b1;
      case (cfg_index)
        rdss_pkg::CFG_DAMPING:      damping_r      <= $signed(cfg_data[17:0]);
        rdss_pkg::CFG_STIFFNESS:    stiffness_r    <= cfg_data;
        rdss_pkg::CFG_REST_LENGTH:  rest_length_r  <= cfg_data[16:0];
        rdss_pkg::CFG_SLIDER_MASS:  slider_mass_r  <= cfg_data[22:0];
        rdss_pkg::CFG_DISK_INERTIA: disk_inertia_r <= cfg_data;
        default: ;
      endcase
    end else if (state_r == rdss_pkg::ST_DKW && div_done) begin
      dirty_r <= 1'b0;
    end
  end

  // multiplier product register: holds while no product is issued
  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_p;
  end

  // divider counter (control)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= rdss_pkg::DIV_STEPS;
    end else begin
      case (state_r)
        rdss_pkg::ST_DB, rdss_pkg::ST_DK, rdss_pkg::ST_DN:
          div_cnt_r <= (div_d == '0) ? rdss_pkg::DIV_STEPS : '0;
        rdss_pkg::ST_DBW, rdss_pkg::ST_DKW, rdss_pkg::ST_DNW:
          if (!div_done) div_cnt_r <= div_cnt_r + 5'd1;
        default: ;
      endcase
    end
  end

  // divider data path
  always_ff @(posedge clk) begin
    case (state_r)
      rdss_pkg::ST_DB, rdss_pkg::ST_DK, rdss_pkg::ST_DN: begin
        div_rem_r  <= '0;
        div_quo_r  <= {div_nmag, 16'd0};
        div_dmag_r <= div_dmag;
        div_zero_r <= (div_d == '0);
        div_nz_r   <= (div_n != '0);
        div_neg_r  <= (div_d == '0) ? div_n[31] : (div_n[31] ^ div_d[31]);
      end
      rdss_pkg::ST_DBW, rdss_pkg::ST_DKW, rdss_pkg::ST_DNW: begin
        if (!div_done) begin
          div_rem_r <= div_s2.rem;
          div_quo_r <= div_s2.quo;
        end
      end
      default: ;
    endcase
  end

  // integrator state and clamp flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r     <= $signed({15'd0, rdss_pkg::RST_REST_LENGTH});
      xd_r    <= '0;
      w_r     <= rdss_pkg::RST_SPIN_RATE;
      flag_r  <= 1'b0;
      sat_b_r <= 1'b0;
      sat_k_r <= 1'b0;
    end else begin
      case (state_r)
        rdss_pkg::ST_IDLE: if (in_valid) flag_r <= 1'b0;
        rdss_pkg::ST_DBW:  if (div_done) sat_b_r <= dres.sat;
        rdss_pkg::ST_DKW:  if (div_done) sat_k_r <= dres.sat;
        rdss_pkg::ST_M1:   flag_r <= flag_r | sat_b_r | sat_k_r;
        rdss_pkg::ST_M2:   flag_r <= flag_r | qm.sat;
        rdss_pkg::ST_M3:   flag_r <= flag_r | qm.sat | kw_c.sat;
        rdss_pkg::ST_M4:   flag_r <= flag_r | qm.sat | acc_a_c.sat;
        rdss_pkg::ST_M5:   flag_r <= flag_r | qm.sat | acc_b_c.sat;
        rdss_pkg::ST_M7: begin
          xd_r   <= xd_c.val;
          flag_r <= flag_r | xd_c.sat;
        end
        rdss_pkg::ST_M9: begin
          x_r    <= x_c.val;
          flag_r <= flag_r | x_c.sat;
        end
        rdss_pkg::ST_M10:  flag_r <= flag_r | r_c.sat;
        rdss_pkg::ST_M12:  flag_r <= flag_r | qm.sat;
        rdss_pkg::ST_M13:  flag_r <= flag_r | qm.sat;
        rdss_pkg::ST_M14:  flag_r <= flag_r | qm.sat;
        rdss_pkg::ST_M15:  flag_r <= flag_r | qm.sat | den_c.sat;
        rdss_pkg::ST_M16:  flag_r <= flag_r | qm.sat;
        rdss_pkg::ST_NUM:  flag_r <= flag_r | p2_c.sat | num_c.sat;
        rdss_pkg::ST_DNW:  if (div_done) flag_r <= flag_r | dres.sat;
        rdss_pkg::ST_W2: begin
          w_r    <= w_c.val;
          flag_r <= flag_r | w_c.sat;
        end
        rdss_pkg::ST_W4: begin
          // freeze drops the state after the word is formed
          if (out_free && frz_r) begin
            x_r  <= ln_s;
            xd_r <= '0;
            w_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // per-tick payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      rdss_pkg::ST_IDLE: begin
        if (in_valid) begin
          tz_r  <= in_torque;
          dt_r  <= in_time_step;
          frz_r <= in_freeze;
        end
      end
      rdss_pkg::ST_DBW: if (div_done) qb_r <= dres.val;
      rdss_pkg::ST_DKW: if (div_done) qk_r <= dres.val;
      rdss_pkg::ST_M2:  w2_r <= qm.val;
      rdss_pkg::ST_M3: begin
        t_r  <= qm.val;
        kw_r <= kw_c.val;
      end
      rdss_pkg::ST_M4:  acc_r <= acc_a_c.val;
      rdss_pkg::ST_M5:  acc_r <= acc_b_c.val;
      rdss_pkg::ST_M10: r_r   <= r_c.val;
      rdss_pkg::ST_M12: p_r   <= qm.val;
      rdss_pkg::ST_M13: t_r   <= qm.val;
      rdss_pkg::ST_M14: p_r   <= qm.val;
      rdss_pkg::ST_M15: den_r <= den_c.val;
      rdss_pkg::ST_M16: p_r   <= qm.val;
      rdss_pkg::ST_NUM: num_r <= num_c.val;
      rdss_pkg::ST_DNW: if (div_done) q_r <= dres.val;
      default: ;
    endcase
  end

  // output register: load at the end of a tick, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == rdss_pkg::ST_W4 && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rdss_pkg::ST_W4 && out_free) begin
      out_pos_r <= r_r;
      out_rot_r <= tm;
      out_w_r   <= w_r;
      out_sat_r <= flag_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_slider_position = out_pos_r;
  assign out_rotation_step   = out_rot_r;
  assign out_angular_speed   = out_w_r;
  assign out_saturated       = out_sat_r;

  // an accepted word always starts a tick
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != rdss_pkg::ST_IDLE))
    else $error("accepted word did not start a tick");

  // a fresh result word comes only from the end of a tick
  a_word_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == rdss_pkg::ST_W4))
    else $error("result word raised outside the end of a tick");

  // the divider counter never runs past its last step
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_cnt_r <= rdss_pkg::DIV_STEPS)
    else $error("divider counter overran");

endmodule
